// ===== rtl/bchc_pkg.sv =====
// Package with shared types and constants for the button click and hold classifier.
package bchc_pkg;

  localparam int unsigned CfgWidth       = 16;
  localparam int unsigned CfgAddrWidth   = 2;
  localparam int unsigned TimeWidthDflt  = 16;
  localparam int unsigned EventWidth     = 3;

  localparam logic [CfgAddrWidth-1:0] RegDebounce = 2'd0;
  localparam logic [CfgAddrWidth-1:0] RegClick    = 2'd1;
  localparam logic [CfgAddrWidth-1:0] RegRelease  = 2'd2;
  localparam logic [CfgAddrWidth-1:0] RegHold     = 2'd3;

  localparam logic [CfgWidth-1:0] DebounceRst = 16'd20;
  localparam logic [CfgWidth-1:0] ClickRst    = 16'd300;
  localparam logic [CfgWidth-1:0] ReleaseRst  = 16'd300;
  localparam logic [CfgWidth-1:0] HoldRst     = 16'd1000;

  localparam logic [EventWidth-1:0] EvNone    = 3'd0;
  localparam logic [EventWidth-1:0] EvSingle  = 3'd1;
  localparam logic [EventWidth-1:0] EvDouble  = 3'd2;
  localparam logic [EventWidth-1:0] EvHold    = 3'd3;
  localparam logic [EventWidth-1:0] EvRelease = 3'd4;
  localparam logic [EventWidth-1:0] EvError   = 3'd5;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ticks;
    logic [CfgWidth-1:0] click_ticks;
    logic [CfgWidth-1:0] release_ticks;
    logic [CfgWidth-1:0] hold_ticks;
  } cfg_t;

endpackage

// ===== rtl/bchc_cfg.sv =====
// Configuration register file for the button click and hold classifier.
module bchc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bchc_pkg::CfgAddrWidth-1:0]   cfg_addr_i,
  input  logic [bchc_pkg::CfgWidth-1:0]       cfg_wdata_i,
  output bchc_pkg::cfg_t                      cfg_o
);

  bchc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= bchc_pkg::DebounceRst;
      cfg_q.click_ticks    <= bchc_pkg::ClickRst;
      cfg_q.release_ticks  <= bchc_pkg::ReleaseRst;
      cfg_q.hold_ticks     <= bchc_pkg::HoldRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bchc_pkg::RegDebounce: cfg_q.debounce_ticks <= cfg_wdata_i;
        bchc_pkg::RegClick:    cfg_q.click_ticks    <= cfg_wdata_i;
        bchc_pkg::RegRelease:  cfg_q.release_ticks  <= cfg_wdata_i;
        bchc_pkg::RegHold:     cfg_q.hold_ticks     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bchc_fsm.sv =====
// Gesture state machine and saturating elapsed-tick counter.
module bchc_fsm #(
  parameter int unsigned TIME_WIDTH = bchc_pkg::TimeWidthDflt
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic                               pressed_i,
  input  bchc_pkg::cfg_t                     cfg_i,
  output logic [bchc_pkg::EventWidth-1:0]    event_o
);

  localparam int unsigned CmpWidth =
    (TIME_WIDTH > bchc_pkg::CfgWidth) ? TIME_WIDTH : bchc_pkg::CfgWidth;

  localparam logic [3:0] PhIdle           = 4'd0;
  localparam logic [3:0] PhDebounce       = 4'd1;
  localparam logic [3:0] PhFirstPress     = 4'd2;
  localparam logic [3:0] PhFirstGap       = 4'd3;
  localparam logic [3:0] PhSingle         = 4'd4;
  localparam logic [3:0] PhSecondDebounce = 4'd5;
  localparam logic [3:0] PhSecondPress    = 4'd6;
  localparam logic [3:0] PhDouble         = 4'd7;
  localparam logic [3:0] PhLongPress      = 4'd8;
  localparam logic [3:0] PhHold           = 4'd9;
  localparam logic [3:0] PhReleaseWait    = 4'd10;
  localparam logic [3:0] PhRelease        = 4'd11;
  localparam logic [3:0] PhError          = 4'd12;

  logic [3:0]            phase_q, phase_d;
  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d, tick;
  logic [CmpWidth-1:0]   tick_x;
  logic                  clr;
  logic                  ge_deb, ge_click, ge_rel, gt_rel, gt_hold;
  logic [bchc_pkg::EventWidth-1:0] ev;

  assign tick   = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign tick_x = CmpWidth'(tick);

  assign ge_deb   = tick_x >= CmpWidth'(cfg_i.debounce_ticks);
  assign ge_click = tick_x >= CmpWidth'(cfg_i.click_ticks);
  assign ge_rel   = tick_x >= CmpWidth'(cfg_i.release_ticks);
  assign gt_rel   = tick_x >  CmpWidth'(cfg_i.release_ticks);
  assign gt_hold  = tick_x >  CmpWidth'(cfg_i.hold_ticks);

  always_comb begin
    phase_d = phase_q;
    clr     = 1'b0;
    ev      = bchc_pkg::EvNone;
    case (phase_q)
      PhDebounce: begin
        if (ge_deb) begin
          if (!pressed_i) begin
            phase_d = PhIdle;
          end else begin
            phase_d = PhFirstPress;
            clr     = 1'b1;
          end
        end
      end
      PhFirstPress: begin
        if (!pressed_i && !ge_click) begin
          phase_d = PhFirstGap;
          clr     = 1'b1;
        end else if (ge_click) begin
          phase_d = PhLongPress;
        end
      end
      PhFirstGap: begin
        if (!pressed_i && ge_rel) begin
          phase_d = PhSingle;
        end else if (pressed_i && !ge_rel) begin
          phase_d = PhSecondDebounce;
          clr     = 1'b1;
        end
      end
      PhSingle: begin
        ev      = bchc_pkg::EvSingle;
        phase_d = PhIdle;
      end
      PhSecondDebounce: begin
        if (ge_deb) begin
          if (!pressed_i) begin
            phase_d = PhSingle;
          end else begin
            phase_d = PhSecondPress;
            clr     = 1'b1;
          end
        end
      end
      PhSecondPress: begin
        if (!pressed_i && !ge_click) begin
          phase_d = PhDouble;
        end else if (pressed_i && ge_click) begin
          phase_d = PhError;
        end
      end
      PhDouble: begin
        ev      = bchc_pkg::EvDouble;
        phase_d = PhIdle;
      end
      PhLongPress: begin
        if (!pressed_i && !gt_hold) begin
          phase_d = PhError;
        end else if (gt_hold) begin
          phase_d = PhHold;
        end
      end
      PhHold: begin
        ev = bchc_pkg::EvHold;
        if (!pressed_i) begin
          phase_d = PhReleaseWait;
          clr     = 1'b1;
        end
      end
      PhReleaseWait: begin
        if (pressed_i && !gt_rel) begin
          phase_d = PhHold;
        end else if (gt_rel) begin
          phase_d = PhRelease;
        end
      end
      PhRelease: begin
        ev      = bchc_pkg::EvRelease;
        phase_d = PhIdle;
      end
      PhError: begin
        ev      = bchc_pkg::EvError;
        phase_d = PhIdle;
      end
      default: begin
        // Idle, and the unused codes behave the same way.
        if (pressed_i) begin
          phase_d = PhDebounce;
          clr     = 1'b1;
        end else begin
          phase_d = PhIdle;
        end
      end
    endcase
  end

  assign elapsed_d = clr ? '0 : tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign event_o = ev;

endmodule

// ===== rtl/button_click_hold_classifier.sv =====
// Top level of the button click and hold classifier with its stream ports.
//
// Each request on the slave stream is one timer tick carrying the sampled
// button level, and each one gives exactly one result on the master stream:
// none, single click, double click, hold, release or error. A request is
// registered, stepped through the gesture state machine once the output
// register is free, and its result is held in that output register, so the
// block takes one request per clock cycle while the master side is ready.
// The elapsed-tick counter saturates at its maximum, and all thresholds can
// be rewritten through the configuration port while the streams are idle.
module button_click_hold_classifier #(
  parameter int unsigned TIME_WIDTH = bchc_pkg::TimeWidthDflt
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bchc_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [bchc_pkg::CfgWidth-1:0]      cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [0] pressed
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata    // [2:0] event_res
);

  bchc_pkg::cfg_t cfg;

  logic                              in_valid_q;
  logic                              pressed_q;
  logic                              out_valid_q;
  logic [bchc_pkg::EventWidth-1:0]   event_q;
  logic [bchc_pkg::EventWidth-1:0]   event_d;
  logic                              out_free;
  logic                              advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  bchc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bchc_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .pressed_i (pressed_q),
    .cfg_i     (cfg),
    .event_o   (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pressed_q <= s_axis_tdata[0];
    end
    if (advance) begin
      event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, event_q};

`ifndef NO_ASSERTIONS
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (event_q <= bchc_pkg::EvError))
    else $error("result event code out of range");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without a buffered request");

  a_request_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("buffered request did not reach the output register");
`endif

endmodule

// ===== sim/tb_button_click_hold_classifier.sv =====
// Self-checking testbench for the button click and hold classifier.
module tb_button_click_hold_classifier;
  import bchc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TimeWidth  = TimeWidthDflt;

  typedef enum logic [3:0] {
    PhIdle,
    PhDebounce,
    PhFirstPress,
    PhFirstGap,
    PhSingle,
    PhSecondDebounce,
    PhSecondPress,
    PhDouble,
    PhLongPress,
    PhHold,
    PhReleaseWait,
    PhRelease,
    PhError
  } gesture_phase_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgAddrWidth-1:0] cfg_addr_i = '0;
  logic [CfgWidth-1:0]     cfg_wdata_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata = '0;  // [0] pressed
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [7:0]              m_axis_tdata;       // [2:0] event_res

  cfg_t                    model_cfg;
  gesture_phase_e          gphase;
  logic [TimeWidth-1:0]    tick_age;

  logic                    level_q[$];
  logic [EventWidth-1:0]   pending_events[$];
  logic [EventWidth-1:0]   want_event;
  bit                      level_sent = 1'b0;
  bit                      idle_on = 1'b0;
  int unsigned             gap_left = 0;
  int unsigned             stall_left = 0;
  int unsigned             queued_cnt = 0;
  int unsigned             result_cnt = 0;
  int unsigned             err_cnt = 0;
  int unsigned             cycle_cnt = 0;

  button_click_hold_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [EventWidth-1:0] classify_tick(input logic pressed);
    logic [EventWidth-1:0] ev;
    logic [TimeWidth-1:0]  t;
    ev = EvNone;
    if (tick_age != '1) tick_age = tick_age + 1'b1;
    t = tick_age;
    case (gphase)
      PhDebounce: begin
        if (t >= model_cfg.debounce_ticks) begin
          if (!pressed) gphase = PhIdle;
          else begin
            gphase = PhFirstPress;
            tick_age = '0;
          end
        end
      end
      PhFirstPress: begin
        if (!pressed && t < model_cfg.click_ticks) begin
          gphase = PhFirstGap;
          tick_age = '0;
        end else if (t >= model_cfg.click_ticks) gphase = PhLongPress;
      end
      PhFirstGap: begin
        if (!pressed && t >= model_cfg.release_ticks) gphase = PhSingle;
        else if (pressed && t < model_cfg.release_ticks) begin
          gphase = PhSecondDebounce;
          tick_age = '0;
        end
      end
      PhSingle: begin
        ev = EvSingle;
        gphase = PhIdle;
      end
      PhSecondDebounce: begin
        if (t >= model_cfg.debounce_ticks) begin
          if (!pressed) gphase = PhSingle;
          else begin
            gphase = PhSecondPress;
            tick_age = '0;
          end
        end
      end
      PhSecondPress: begin
        if (!pressed && t < model_cfg.click_ticks) gphase = PhDouble;
        else if (pressed && t >= model_cfg.click_ticks) gphase = PhError;
      end
      PhDouble: begin
        ev = EvDouble;
        gphase = PhIdle;
      end
      PhLongPress: begin
        if (!pressed && t <= model_cfg.hold_ticks) gphase = PhError;
        else if (t > model_cfg.hold_ticks) gphase = PhHold;
      end
      PhHold: begin
        ev = EvHold;
        if (!pressed) begin
          gphase = PhReleaseWait;
          tick_age = '0;
        end
      end
      PhReleaseWait: begin
        if (pressed && t <= model_cfg.release_ticks) gphase = PhHold;
        else if (t > model_cfg.release_ticks) gphase = PhRelease;
      end
      PhRelease: begin
        ev = EvRelease;
        gphase = PhIdle;
      end
      PhError: begin
        ev = EvError;
        gphase = PhIdle;
      end
      default: begin
        if (pressed) begin
          gphase = PhDebounce;
          tick_age = '0;
        end else gphase = PhIdle;
      end
    endcase
    return ev;
  endfunction

  // Request driver: one level per request, random gaps only between requests.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (level_sent) void'(level_q.pop_front());
      if (s_axis_tvalid && !level_sent) begin
        s_axis_tvalid <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 3) - 1;
        s_axis_tvalid <= 1'b0;
      end else if (level_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, level_q[0]};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker; the comparison runs before the new request is predicted.
  always @(posedge clk_i) begin
    level_sent <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (pending_events.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("result %0d: event %0d arrived with nothing pending",
                   result_cnt, m_axis_tdata[2:0]);
      end else begin
        want_event = pending_events.pop_front();
        if (m_axis_tdata[2:0] !== want_event) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result %0d: expected event %0d, got %0d",
                     result_cnt, want_event, m_axis_tdata[2:0]);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_events.push_back(classify_tick(s_axis_tdata[0]));
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgAddrWidth-1:0] idx, input logic [CfgWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegDebounce: model_cfg.debounce_ticks = val;
      RegClick:    model_cfg.click_ticks = val;
      RegRelease:  model_cfg.release_ticks = val;
      RegHold:     model_cfg.hold_ticks = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_cfg(input logic [CfgWidth-1:0] db, input logic [CfgWidth-1:0] ck,
                           input logic [CfgWidth-1:0] rl, input logic [CfgWidth-1:0] hd);
    write_reg(RegDebounce, db);
    write_reg(RegClick, ck);
    write_reg(RegRelease, rl);
    write_reg(RegHold, hd);
  endtask

  task automatic start_phase(input bit idling);
    @(posedge clk_i);
    idle_on = idling;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (level_q.size() != 0 || s_axis_tvalid);
    while (pending_events.size() != 0) @(negedge clk_i);
  endtask

  task automatic queue_level(input logic lvl, input int unsigned n);
    repeat (n) level_q.push_back(lvl);
    queued_cnt += n;
  endtask

  function automatic int unsigned near_len(input int unsigned thr);
    int unsigned base;
    base = (thr > 40) ? $urandom_range(1, 40) : thr;
    case ($urandom_range(0, 4))
      0: return (base > 1) ? base - 1 : 1;
      1: return (base > 0) ? base : 1;
      2: return base + 1;
      3: return base + 2;
      default: return $urandom_range(1, 2 * base + 3);
    endcase
  endfunction

  function automatic logic [CfgWidth-1:0] pick_threshold();
    case ($urandom_range(0, 19))
      0, 1:   return '0;
      2:      return '1;
      3, 4:   return CfgWidth'($urandom_range(7, 20));
      default: return CfgWidth'($urandom_range(1, 6));
    endcase
  endfunction

  // Mostly well-formed press/release sequences timed around the thresholds.
  task automatic queue_gesture();
    int unsigned presses;
    int unsigned plen;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 8)) queue_level(1'($urandom_range(0, 1)), 1);
    end else begin
      presses = $urandom_range(1, 3);
      for (int i = 0; i < presses; i++) begin
        case ($urandom_range(0, 2))
          0: plen = near_len(model_cfg.debounce_ticks) + 1;
          1: plen = near_len(model_cfg.debounce_ticks) + near_len(model_cfg.click_ticks);
          default: plen = near_len(model_cfg.debounce_ticks) + near_len(model_cfg.click_ticks)
                          + near_len(model_cfg.hold_ticks);
        endcase
        queue_level(1'b1, plen);
        if (i + 1 < presses) begin
          if ($urandom_range(0, 1) == 0) queue_level(1'b0, near_len(model_cfg.release_ticks));
          else queue_level(1'b0, $urandom_range(1, 3));
        end
      end
      queue_level(1'b0, near_len(model_cfg.release_ticks) + near_len(model_cfg.release_ticks)
                        + $urandom_range(1, 4));
    end
  endtask

  task automatic queue_gestures(input int unsigned n);
    int unsigned start;
    start = queued_cnt;
    while (queued_cnt - start < n) queue_gesture();
  endtask

  initial begin
    model_cfg = '{debounce_ticks: DebounceRst, click_ticks: ClickRst,
                  release_ticks: ReleaseRst, hold_ticks: HoldRst};
    gphase = PhIdle;
    tick_age = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers at their reset values.
    start_phase(1'b1);
    repeat (40) queue_level(1'($urandom_range(0, 1)), 1);
    drain();

    // Single click, double click, hold with a resumed press, late second release.
    apply_cfg(16'd1, 16'd3, 16'd2, 16'd4);
    start_phase(1'b1);
    queue_level(1'b1, 2); queue_level(1'b0, 4);
    queue_level(1'b1, 2); queue_level(1'b0, 1); queue_level(1'b1, 3); queue_level(1'b0, 2);
    queue_level(1'b1, 9); queue_level(1'b0, 1); queue_level(1'b1, 2); queue_level(1'b0, 5);
    queue_level(1'b1, 2); queue_level(1'b0, 1); queue_level(1'b1, 4); queue_level(1'b0, 2);
    queue_level(1'b1, 1); queue_level(1'b0, 2);
    drain();

    apply_cfg('0, '0, '0, '0);
    start_phase(1'b1);
    queue_gestures(200);
    drain();

    repeat (8) begin
      apply_cfg(pick_threshold(), pick_threshold(), pick_threshold(), pick_threshold());
      start_phase($urandom_range(0, 3) != 0);
      queue_gestures(140);
      drain();
    end

    // A press far below the largest hold threshold stays a long press and ends in an error.
    apply_cfg('0, '0, '1, '1);
    start_phase(1'b0);
    queue_level(1'b1, 60);
    queue_level(1'b0, 4);
    drain();

    apply_cfg(16'd2, 16'd4, 16'd3, 16'd6);
    start_phase(1'b0);
    queue_gestures(150);
    drain();

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bchc_pkg.sv
rtl/bchc_cfg.sv
rtl/bchc_fsm.sv
rtl/button_click_hold_classifier.sv
sim/tb_button_click_hold_classifier.sv
